[rtl/lpd_pkg.sv]
package lpd_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 16;

  localparam logic [1:0] REG_PROTO_DET = 2'd0;
  localparam logic [1:0] REG_MOD_EN    = 2'd1;
  localparam logic [1:0] REG_FRAME_DIS = 2'd2;
  localparam logic [1:0] REG_MAX_LEN   = 2'd3;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd2048;

  typedef enum logic [1:0] {
    PH_LEN_LO  = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_DATA    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  typedef struct packed {
    logic             protocol_detected;
    logic             module_enabled;
    logic             framing_disabled;
    logic [LEN_W-1:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
    logic       empty_frame;
    logic       passthrough;
  } res_t;

endpackage

[rtl/length_prefixed_deframer.sv]
// channel | direction | handshake                  | payload
// in      | input     | in_valid / in_ready        | in_rx_byte, in_chunk_end
// out     | output    | out_valid / out_ready      | out_byte, out_frame_last,
//         |           |                            | out_empty_frame, out_passthrough
// cfg     | input     | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// one input beat per cycle while in_ready is high; a result is registered into
// the output entry, or the skid entry if out stalls; the parse state and 16-bit
// compare and increment feed this two-entry output register, which sets the rate
// in_ready is low only while both output entries hold results
// synchronous active-low reset clears the parse state, registers and valids
module length_prefixed_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        in_chunk_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_frame_last,
  output logic                        out_empty_frame,
  output logic                        out_passthrough,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [lpd_pkg::DATA_W-1:0]  pwdata,
  output logic [lpd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  lpd_pkg::cfg_t cfg_r;
  logic [1:0]    reg_idx;
  logic          cfg_wr;
  logic          beat;
  logic          res_valid;
  lpd_pkg::res_t res;
  logic          out_v_r, out_v_nxt;
  logic          skd_v_r, skd_v_nxt;
  lpd_pkg::res_t out_d_r, out_d_nxt;
  lpd_pkg::res_t skd_d_r, skd_d_nxt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protocol_detected <= 1'b0;
      cfg_r.module_enabled    <= 1'b0;
      cfg_r.framing_disabled  <= 1'b0;
      cfg_r.max_frame_length  <= lpd_pkg::MAX_LEN_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        lpd_pkg::REG_PROTO_DET: cfg_r.protocol_detected <= pwdata[0];
        lpd_pkg::REG_MOD_EN:    cfg_r.module_enabled    <= pwdata[0];
        lpd_pkg::REG_FRAME_DIS: cfg_r.framing_disabled  <= pwdata[0];
        lpd_pkg::REG_MAX_LEN:   cfg_r.max_frame_length  <= pwdata[lpd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lpd_pkg::REG_PROTO_DET: prdata = lpd_pkg::DATA_W'(cfg_r.protocol_detected);
      lpd_pkg::REG_MOD_EN:    prdata = lpd_pkg::DATA_W'(cfg_r.module_enabled);
      lpd_pkg::REG_FRAME_DIS: prdata = lpd_pkg::DATA_W'(cfg_r.framing_disabled);
      lpd_pkg::REG_MAX_LEN:   prdata = lpd_pkg::DATA_W'(cfg_r.max_frame_length);
      default:                prdata = '0;
    endcase
  end

  assign in_ready = !skd_v_r;
  assign beat     = in_valid && in_ready;

  lpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .beat      (beat),
    .rx_byte   (in_rx_byte),
    .chunk_end (in_chunk_end),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_v_nxt = out_v_r;
    skd_v_nxt = skd_v_r;
    out_d_nxt = out_d_r;
    skd_d_nxt = skd_d_r;
    if (!out_v_r || out_ready) begin
      if (skd_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = skd_d_r;
        skd_v_nxt = 1'b0;
      end else begin
        out_v_nxt = beat && res_valid;
        out_d_nxt = res;
      end
    end else if (beat && res_valid) begin
      skd_v_nxt = 1'b1;
      skd_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skd_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      skd_v_r <= skd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    skd_d_r <= skd_d_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_byte        = out_d_r.out_byte;
  assign out_frame_last  = out_d_r.frame_last;
  assign out_empty_frame = out_d_r.empty_frame;
  assign out_passthrough = out_d_r.passthrough;

endmodule

[rtl/lpd_parser.sv]
module lpd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  lpd_pkg::cfg_t cfg,
  input  logic          beat,
  input  logic [7:0]    rx_byte,
  input  logic          chunk_end,
  output logic          res_valid,
  output lpd_pkg::res_t res
);

  lpd_pkg::phase_t            phase_r, phase_nxt;
  logic [lpd_pkg::LEN_W-1:0]  frame_len_r, frame_len_nxt;
  logic [lpd_pkg::LEN_W-1:0]  bytes_r, bytes_nxt;
  logic [lpd_pkg::LEN_W-1:0]  new_len;
  logic [lpd_pkg::LEN_W-1:0]  bytes_inc;
  logic                       framing_on;

  assign framing_on = cfg.protocol_detected && cfg.module_enabled && !cfg.framing_disabled;
  assign new_len    = {rx_byte, frame_len_r[7:0]};
  assign bytes_inc  = bytes_r + lpd_pkg::LEN_W'(1);

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    bytes_nxt     = bytes_r;
    res_valid     = 1'b0;
    res           = '0;
    if (!framing_on) begin
      // raw forward, only a chunk end leaves discard
      if (chunk_end && phase_r == lpd_pkg::PH_DISCARD) begin
        phase_nxt = lpd_pkg::PH_LEN_LO;
      end
      res_valid       = 1'b1;
      res.out_byte    = rx_byte;
      res.passthrough = 1'b1;
    end else begin
      case (phase_r)
        lpd_pkg::PH_LEN_LO: begin
          frame_len_nxt = {frame_len_r[15:8], rx_byte};
          phase_nxt     = lpd_pkg::PH_LEN_HI;
        end
        lpd_pkg::PH_LEN_HI: begin
          frame_len_nxt = new_len;
          bytes_nxt     = '0;
          if (new_len > cfg.max_frame_length) begin
            phase_nxt = chunk_end ? lpd_pkg::PH_LEN_LO : lpd_pkg::PH_DISCARD;
          end else if (new_len == '0) begin
            phase_nxt       = lpd_pkg::PH_LEN_LO;
            res_valid       = 1'b1;
            res.frame_last  = 1'b1;
            res.empty_frame = 1'b1;
          end else begin
            phase_nxt = lpd_pkg::PH_DATA;
          end
        end
        lpd_pkg::PH_DATA: begin
          res_valid    = 1'b1;
          res.out_byte = rx_byte;
          if (bytes_inc >= frame_len_r) begin
            res.frame_last = 1'b1;
            phase_nxt      = lpd_pkg::PH_LEN_LO;
            bytes_nxt      = '0;
          end else begin
            bytes_nxt = bytes_inc;
          end
        end
        default: begin
          if (chunk_end) begin
            phase_nxt = lpd_pkg::PH_LEN_LO;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lpd_pkg::PH_LEN_LO;
      frame_len_r <= '0;
      bytes_r     <= '0;
    end else if (beat) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      bytes_r     <= bytes_nxt;
    end
  end

endmodule

[rtl/lpd_checker.sv]
module lpd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [7:0]                  out_byte,
  input logic                        out_frame_last,
  input logic                        out_empty_frame,
  input logic                        out_passthrough,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [lpd_pkg::ADDR_W-1:0]  paddr,
  input logic [lpd_pkg::DATA_W-1:0]  pwdata,
  input logic [lpd_pkg::DATA_W-1:0]  prdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_frame_last)
      && $stable(out_empty_frame) && $stable(out_passthrough))
    else $error("stalled result beat changed");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_frame |-> out_frame_last && out_byte == 8'd0 && !out_passthrough)
    else $error("empty frame beat malformed");

  a_raw_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_passthrough |-> !out_frame_last && !out_empty_frame)
    else $error("raw beat carries frame flags");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_max_len_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[3:2] == lpd_pkg::REG_MAX_LEN
      |=> !(paddr[3:2] == lpd_pkg::REG_MAX_LEN)
        || prdata == lpd_pkg::DATA_W'($past(pwdata[lpd_pkg::LEN_W-1:0])))
    else $error("max frame length readback mismatch");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_frame_last  (out_frame_last),
  .out_empty_frame (out_empty_frame),
  .out_passthrough (out_passthrough),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);

[test/tb_length_prefixed_deframer.sv]
module tb_length_prefixed_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 150000;
  localparam int SETTLE      = 4;

  typedef struct {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } rx_item_t;

  logic                       clk;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_rx_byte   = '0;
  logic                       in_chunk_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic [7:0]                 out_byte;
  logic                       out_frame_last;
  logic                       out_empty_frame;
  logic                       out_passthrough;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [lpd_pkg::ADDR_W-1:0] paddr        = '0;
  logic [lpd_pkg::DATA_W-1:0] pwdata       = '0;
  logic [lpd_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  rx_item_t      rx_pending_q[$];
  lpd_pkg::res_t due_out_q[$];

  lpd_pkg::cfg_t             cfg_shadow;
  lpd_pkg::phase_t           parse_st;
  logic [lpd_pkg::LEN_W-1:0] len_cur;
  logic [lpd_pkg::LEN_W-1:0] paid_cnt;

  int in_sent;
  int in_accepted;
  int out_seen;
  int errors;
  int cycles;
  int settings_run;
  int idle_odds;
  int in_gap;
  int out_gap;

  length_prefixed_deframer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_chunk_end   (in_chunk_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_frame_last (out_frame_last),
    .out_empty_frame(out_empty_frame),
    .out_passthrough(out_passthrough),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void deframe_byte(logic [7:0] b, logic ce);
    lpd_pkg::res_t r;
    r = '0;
    if (!cfg_shadow.protocol_detected || !cfg_shadow.module_enabled ||
        cfg_shadow.framing_disabled) begin
      if (ce && parse_st == lpd_pkg::PH_DISCARD) parse_st = lpd_pkg::PH_LEN_LO;
      r.out_byte    = b;
      r.passthrough = 1'b1;
      due_out_q.push_back(r);
    end else begin
      case (parse_st)
        lpd_pkg::PH_LEN_LO: begin
          len_cur[7:0] = b;
          parse_st = lpd_pkg::PH_LEN_HI;
        end
        lpd_pkg::PH_LEN_HI: begin
          len_cur[15:8] = b;
          paid_cnt = '0;
          if (len_cur > cfg_shadow.max_frame_length) begin
            parse_st = ce ? lpd_pkg::PH_LEN_LO : lpd_pkg::PH_DISCARD;
          end else if (len_cur == '0) begin
            parse_st = lpd_pkg::PH_LEN_LO;
            r.frame_last  = 1'b1;
            r.empty_frame = 1'b1;
            due_out_q.push_back(r);
          end else begin
            parse_st = lpd_pkg::PH_DATA;
          end
        end
        lpd_pkg::PH_DATA: begin
          paid_cnt = paid_cnt + 16'd1;
          r.out_byte = b;
          if (paid_cnt >= len_cur) begin
            r.frame_last = 1'b1;
            parse_st = lpd_pkg::PH_LEN_LO;
            paid_cnt = '0;
          end
          due_out_q.push_back(r);
        end
        default: begin
          if (ce) parse_st = lpd_pkg::PH_LEN_LO;
        end
      endcase
    end
  endfunction

  // input beats
  always @(negedge clk) begin
    rx_item_t item;
    if (!(in_valid && in_sent != in_accepted)) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        in_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (rx_pending_q.size() != 0) begin
        item = rx_pending_q.pop_front();
        in_sent++;
        in_valid     <= 1'b1;
        in_rx_byte   <= item.rx_byte;
        in_chunk_end <= item.chunk_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_gap = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lpd_pkg::res_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_accepted++;
        deframe_byte(in_rx_byte, in_chunk_end);
      end
      if (out_valid && out_ready) begin
        out_seen++;
        if (due_out_q.size() == 0) begin
          $error("unexpected out beat: out_byte=%0h", out_byte);
          errors++;
        end else begin
          want = due_out_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
            errors++;
          end
          if (out_frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, out_frame_last);
            errors++;
          end
          if (out_empty_frame !== want.empty_frame) begin
            $error("empty_frame: expected %0b, got %0b", want.empty_frame, out_empty_frame);
            errors++;
          end
          if (out_passthrough !== want.passthrough) begin
            $error("passthrough: expected %0b, got %0b", want.passthrough, out_passthrough);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void queue_rx(logic [7:0] b, logic ce);
    rx_pending_q.push_back('{b, ce});
  endfunction

  task automatic wait_idle();
    while (rx_pending_q.size() != 0 || in_sent != in_accepted || due_out_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [lpd_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      lpd_pkg::REG_PROTO_DET: cfg_shadow.protocol_detected = val[0];
      lpd_pkg::REG_MOD_EN:    cfg_shadow.module_enabled    = val[0];
      lpd_pkg::REG_FRAME_DIS: cfg_shadow.framing_disabled  = val[0];
      lpd_pkg::REG_MAX_LEN:   cfg_shadow.max_frame_length  = val[lpd_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper bits are junk the block must ignore
  task automatic apply_setting(logic pd, logic me, logic fd,
                               logic [lpd_pkg::LEN_W-1:0] max_len);
    wait_idle();
    apb_write(lpd_pkg::REG_PROTO_DET, {16'($urandom_range(0, 65535)), 15'($urandom()), pd});
    apb_write(lpd_pkg::REG_MOD_EN,    {16'($urandom_range(0, 65535)), 15'($urandom()), me});
    apb_write(lpd_pkg::REG_FRAME_DIS, {16'($urandom_range(0, 65535)), 15'($urandom()), fd});
    apb_write(lpd_pkg::REG_MAX_LEN,   {16'($urandom()), max_len});
    settings_run++;
  endtask

  task automatic gen_traffic(int target);
    int  made;
    int  len;
    int  lim;
    int  sel;
    int  n;
    bit  framing;
    made    = 0;
    framing = cfg_shadow.protocol_detected && cfg_shadow.module_enabled &&
              !cfg_shadow.framing_disabled;
    lim     = cfg_shadow.max_frame_length;
    while (made < target) begin
      sel = $urandom_range(0, 9);
      if (!framing || sel == 9) begin
        n = $urandom_range(1, 3);
        repeat (n) queue_rx(8'($urandom()), $urandom_range(0, 3) == 0);
        made += n;
      end else begin
        if (sel < 2 && lim < 65535)
          len = (sel == 0) ? lim + 1 : $urandom_range(lim + 1, 65535);
        else if (sel == 2 && lim <= 64)
          len = lim;
        else
          len = $urandom_range(0, (lim < 20) ? lim : 20);
        queue_rx(len[7:0], $urandom_range(0, 3) == 0);
        if (len > lim) begin
          if ($urandom_range(0, 2) == 0) begin
            queue_rx(len[15:8], 1'b1);
          end else begin
            queue_rx(len[15:8], 1'b0);
            n = $urandom_range(0, 4);
            repeat (n) queue_rx(8'($urandom()), 1'b0);
            queue_rx(8'($urandom()), 1'b1);
          end
        end else begin
          queue_rx(len[15:8], $urandom_range(0, 3) == 0);
          for (int i = 0; i < len; i++)
            queue_rx(8'($urandom()), $urandom_range(0, 4) == 0);
          made += len;
        end
        made += 2;
        if ($urandom_range(0, 59) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    cfg_shadow.protocol_detected = 1'b0;
    cfg_shadow.module_enabled    = 1'b0;
    cfg_shadow.framing_disabled  = 1'b0;
    cfg_shadow.max_frame_length  = lpd_pkg::MAX_LEN_RESET;
    parse_st  = lpd_pkg::PH_LEN_LO;
    len_cur   = '0;
    paid_cnt  = '0;
    idle_odds = 4;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // raw bytes straight out of reset
    queue_rx(8'h00, 1'b0);
    queue_rx(8'hFF, 1'b1);
    wait_idle();
    apb_write(lpd_pkg::REG_PROTO_DET, 32'd1);
    apb_write(lpd_pkg::REG_MOD_EN, 32'd1);
    apb_write(lpd_pkg::REG_FRAME_DIS, 32'd0);
    settings_run++;

    // empty frame, one-byte frame, oversized with and without chunk end, frame over chunks
    queue_rx(8'h00, 1'b0); queue_rx(8'h00, 1'b0);
    queue_rx(8'h01, 1'b0); queue_rx(8'h00, 1'b0); queue_rx(8'hFF, 1'b1);
    queue_rx(8'h01, 1'b0); queue_rx(8'h08, 1'b0); queue_rx(8'h11, 1'b0); queue_rx(8'h22, 1'b1);
    queue_rx(8'h01, 1'b0); queue_rx(8'h08, 1'b1);
    queue_rx(8'h03, 1'b0); queue_rx(8'h00, 1'b0);
    queue_rx(8'hAA, 1'b1); queue_rx(8'hBB, 1'b0); queue_rx(8'hCC, 1'b1);
    queue_rx(8'hFF, 1'b0); queue_rx(8'hFF, 1'b0);
    wait_idle();

    // raw bytes while discarding; chunk end leaves discard
    apb_write(lpd_pkg::REG_FRAME_DIS, 32'd1);
    queue_rx(8'h5A, 1'b0);
    queue_rx(8'h00, 1'b1);
    wait_idle();
    apb_write(lpd_pkg::REG_FRAME_DIS, 32'd0);
    queue_rx(8'h02, 1'b0); queue_rx(8'h00, 1'b0); queue_rx(8'h80, 1'b0); queue_rx(8'h7F, 1'b1);

    apply_setting(1'b1, 1'b1, 1'b0, 16'd2048);
    idle_odds = 4;
    gen_traffic(40);
    wait_idle();
    gen_traffic(40);
    apply_setting(1'b1, 1'b1, 1'b0, 16'd0);
    idle_odds = 8;
    gen_traffic(80);
    apply_setting(1'b1, 1'b1, 1'b0, 16'hFFFF);
    idle_odds = 3;
    gen_traffic(80);
    apply_setting(1'b0, 1'b1, 1'b0, 16'($urandom()));
    idle_odds = 6;
    gen_traffic(80);
    apply_setting(1'b1, 1'b1, 1'b0, 16'($urandom_range(1, 40)));
    idle_odds = 5;
    gen_traffic(80);
    apply_setting(1'b1, 1'b0, 1'b0, 16'd300);
    idle_odds = 10;
    gen_traffic(80);
    apply_setting(1'b1, 1'b1, 1'b1, 16'd8);
    idle_odds = 4;
    gen_traffic(80);
    apply_setting(1'b1, 1'b1, 1'b0, 16'd16);
    idle_odds = 0;
    gen_traffic(80);
    wait_idle();

    $display("%0d input beats and %0d output beats checked across %0d register settings",
             in_accepted, out_seen, settings_run);
    $display("passthrough, empty, oversized, discard and chunk-spanning frames exercised");
    if (errors == 0 && due_out_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lpd_pkg.sv
rtl/lpd_parser.sv
rtl/length_prefixed_deframer.sv
rtl/lpd_checker.sv
test/tb_length_prefixed_deframer.sv
